// File: sv/glos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid line-of-sight package
// Shared constants, payload types and codes for the line-of-sight block.
// ----------------------------------------------------------------------------
package glos_pkg;

	localparam int MapW     = 64;
	localparam int MapH     = 64;
	localparam int MaxSteps = 1024;
	localparam int CxW      = $clog2(MapW);
	localparam int CyW      = $clog2(MapH);
	localparam int AddrW    = CxW + CyW;
	localparam int MapDepth = MapW * MapH;
	localparam int NW       = $clog2(MaxSteps + 1);

	localparam logic CmdWrite = 1'b0;
	localparam logic CmdQuery = 1'b1;

	localparam logic [12:0] StepReset = 13'd128;
	localparam logic [12:0] StepMin   = 13'd16;
	localparam logic [12:0] StepMax   = 13'd4096;

	// Sample positions in Q8.8 that still fall on the map after truncation.
	localparam logic signed [17:0] PosMin  = -18'sd255;
	localparam logic signed [17:0] PosXLim = 18'(MapW * 256);
	localparam logic signed [17:0] PosYLim = 18'(MapH * 256);

	typedef struct packed {
		logic               cmd;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic [5:0]         cell_x;
		logic [5:0]         cell_y;
		logic               wall;
	} in_word_t;

	typedef struct packed {
		logic visible;
		logic steps_saturated;
	} out_word_t;

endpackage

// File: sv/glos_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid line-of-sight channels
// Valid/ready channels for command words, result words and step writes.
// ----------------------------------------------------------------------------
interface glos_in_if;
	logic                valid;
	logic                ready;
	glos_pkg::in_word_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface glos_out_if;
	logic                valid;
	logic                ready;
	glos_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface glos_cfg_if;
	logic        valid;
	logic        ready;
	logic [12:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: sv/glos_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module glos_ram #(
	parameter int Width = 1,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/grid_line_of_sight.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid line of sight
// Keeps a wall map in RAM and marches a sampled ray through it per query.
// ----------------------------------------------------------------------------
//  channel   dir   payload
//  in_ch     in    cmd, start/end points, cell, wall
//  out_ch    out   visible, steps_saturated
//  cfg_ch    in    step_size
//
// After reset a clearing pass opens every cell; no word is taken meanwhile. A write
// goes to the map as it is taken. A query runs the square root, the step division
// and the count check; with n above 1 it adds the per-axis division and, for up to
// n-1 samples, an advance, a map read and a check each. The result waits in an
// output register; the next word is taken once it is delivered.
// ----------------------------------------------------------------------------
module grid_line_of_sight (
	input  logic       clk,
	input  logic       arst_n,
	glos_in_if.sink    in_ch,
	glos_out_if.source out_ch,
	glos_cfg_if.sink   cfg_ch
);
	import glos_pkg::*;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_SQRT  = 10'b0000000100,
		S_NDIV  = 10'b0000001000,
		S_NCHK  = 10'b0000010000,
		S_DDIV  = 10'b0000100000,
		S_STEP  = 10'b0001000000,
		S_CELL  = 10'b0010000000,
		S_CHK   = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [12:0] step_q;
	logic [AddrW-1:0] clr_q;

	logic signed [15:0] ax_q, ay_q;
	logic signed [16:0] dx_q, dy_q;
	logic [33:0] rad_q;
	logic [19:0] rem_q;      // square root remainder
	logic [16:0] root_q;
	logic [4:0]  cnt_q;
	logic [12:0] nrem_q;
	logic [16:0] nq_q;       // quotient of root / step
	logic [NW-1:0] n_q, i_q;
	logic sat_q, vis_q, off_q;
	// |d| / n per axis: the dividend shifts out as the quotient bits come in.
	logic [15:0] qx_q, qy_q;
	logic [NW-1:0] rx_q, ry_q;
	// Running trunc(|d| * i / n) and its remainder.
	logic [15:0] accx_q, accy_q;
	logic [NW-1:0] racx_q, racy_q;

	// Step clamp.
	logic [12:0] step_eff;
	always_comb begin
		step_eff = step_q;
		if (step_q < StepMin) step_eff = StepMin;
		if (step_q > StepMax) step_eff = StepMax;
	end

	// Handshakes.
	assign in_ch.ready  = (state_q == S_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.data.visible = vis_q;
	assign out_ch.data.steps_saturated = sat_q;

	wire in_acc = in_ch.valid && in_ch.ready;

	// Deltas, squares and division steps.
	logic [15:0] adx, ady;
	assign adx = 16'(dx_q[16] ? -dx_q : dx_q);
	assign ady = 16'(dy_q[16] ? -dy_q : dy_q);
	logic [31:0] sqx, sqy;
	assign sqx = adx * adx;
	assign sqy = ady * ady;

	logic [21:0] sq_part, sq_trial;
	assign sq_part  = {rem_q, rad_q[33:32]};
	assign sq_trial = {3'b000, root_q, 2'b01};

	logic [13:0] nd_part;
	assign nd_part = {nrem_q, root_q[16]};

	logic [NW:0] xd_part, yd_part, xr_sum, yr_sum;
	assign xd_part = {rx_q, qx_q[15]};
	assign yd_part = {ry_q, qy_q[15]};
	assign xr_sum  = {1'b0, racx_q} + {1'b0, rx_q};
	assign yr_sum  = {1'b0, racy_q} + {1'b0, ry_q};

	// Sample position and cell.
	logic signed [17:0] ax_ext, ay_ext, ox, oy, px, py;
	assign ax_ext = $signed({{2{ax_q[15]}}, ax_q});
	assign ay_ext = $signed({{2{ay_q[15]}}, ay_q});
	assign ox = $signed({2'b00, accx_q});
	assign oy = $signed({2'b00, accy_q});
	assign px = dx_q[16] ? ax_ext - ox : ax_ext + ox;
	assign py = dy_q[16] ? ay_ext - oy : ay_ext + oy;

	logic off;
	logic [CxW-1:0] cx;
	logic [CyW-1:0] cy;
	assign off = px < PosMin || px >= PosXLim || py < PosMin || py >= PosYLim;
	// A position just left of or above zero truncates to cell 0.
	assign cx = px[17] ? '0 : px[CxW+7:8];
	assign cy = py[17] ? '0 : py[CyW+7:8];

	// Map RAM.
	logic ram_we, ram_wd, ram_rd;
	logic [AddrW-1:0] ram_wa, ram_ra;
	always_comb begin
		ram_we = 1'b0;
		ram_wa = {in_ch.data.cell_y[CyW-1:0], in_ch.data.cell_x[CxW-1:0]};
		ram_wd = in_ch.data.wall;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
			ram_wa = clr_q;
			ram_wd = 1'b0;
		end else if (in_acc && in_ch.data.cmd == CmdWrite) begin
			ram_we = 1'b1;
		end
	end
	assign ram_ra = {cy, cx};

	glos_ram #(.Width(1), .Depth(MapDepth)) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_wa),
		.wdata(ram_wd),
		.raddr(ram_ra),
		.rdata(ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			step_q  <= StepReset;
			clr_q   <= '0;
		end else begin
			if (cfg_ch.valid) step_q <= cfg_ch.data;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AddrW'(MapDepth - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_acc && in_ch.data.cmd == CmdQuery) state_q <= S_SQRT;
				S_SQRT: if (cnt_q == 5'd1) state_q <= S_NDIV;
				S_NDIV: if (cnt_q == 5'd1) state_q <= S_NCHK;
				S_NCHK: state_q <= (nq_q > 17'd1) ? S_DDIV : S_OUT;
				S_DDIV: if (cnt_q == 5'd1) state_q <= S_STEP;
				S_STEP: state_q <= S_CELL;
				S_CELL: state_q <= S_CHK;
				S_CHK: begin
					if (off_q || ram_rd || i_q == n_q - NW'(1)) state_q <= S_OUT;
					else state_q <= S_STEP;
				end
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ax_q  <= in_ch.data.start_x;
				ay_q  <= in_ch.data.start_y;
				dx_q  <= 17'(in_ch.data.end_x) - 17'(in_ch.data.start_x);
				dy_q  <= 17'(in_ch.data.end_y) - 17'(in_ch.data.start_y);
				cnt_q <= 5'd18;
				vis_q <= 1'b1;
				sat_q <= 1'b0;
			end
			S_SQRT: begin
				// First cycle loads the radicand, then two bits per cycle.
				if (cnt_q == 5'd18) begin
					rad_q  <= 34'(sqx) + 34'(sqy);
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					if (sq_part >= sq_trial) begin
						rem_q  <= 20'(sq_part - sq_trial);
						root_q <= {root_q[15:0], 1'b1};
					end else begin
						rem_q  <= 20'(sq_part);
						root_q <= {root_q[15:0], 1'b0};
					end
					rad_q <= {rad_q[31:0], 2'b00};
				end
				nrem_q <= '0;
				cnt_q  <= (cnt_q == 5'd1) ? 5'd17 : cnt_q - 5'd1;
			end
			S_NDIV: begin
				if (nd_part >= {1'b0, step_eff}) begin
					nrem_q <= 13'(nd_part - {1'b0, step_eff});
					nq_q   <= {nq_q[15:0], 1'b1};
				end else begin
					nrem_q <= 13'(nd_part);
					nq_q   <= {nq_q[15:0], 1'b0};
				end
				root_q <= {root_q[15:0], 1'b0};
				cnt_q  <= cnt_q - 5'd1;
			end
			S_NCHK: begin
				if (nq_q > 17'(MaxSteps)) begin
					n_q   <= NW'(MaxSteps);
					sat_q <= 1'b1;
				end else begin
					n_q <= NW'(nq_q);
				end
				qx_q   <= adx;
				qy_q   <= ady;
				rx_q   <= '0;
				ry_q   <= '0;
				accx_q <= '0;
				accy_q <= '0;
				racx_q <= '0;
				racy_q <= '0;
				i_q    <= '0;
				cnt_q  <= 5'd16;
			end
			S_DDIV: begin
				if (xd_part >= {1'b0, n_q}) begin
					rx_q <= NW'(xd_part - {1'b0, n_q});
					qx_q <= {qx_q[14:0], 1'b1};
				end else begin
					rx_q <= NW'(xd_part);
					qx_q <= {qx_q[14:0], 1'b0};
				end
				if (yd_part >= {1'b0, n_q}) begin
					ry_q <= NW'(yd_part - {1'b0, n_q});
					qy_q <= {qy_q[14:0], 1'b1};
				end else begin
					ry_q <= NW'(yd_part);
					qy_q <= {qy_q[14:0], 1'b0};
				end
				cnt_q <= cnt_q - 5'd1;
			end
			S_STEP: begin
				// Adding |d| to |d|*i moves the quotient by q or q+1.
				if (xr_sum >= {1'b0, n_q}) begin
					racx_q <= NW'(xr_sum - {1'b0, n_q});
					accx_q <= accx_q + qx_q + 16'd1;
				end else begin
					racx_q <= NW'(xr_sum);
					accx_q <= accx_q + qx_q;
				end
				if (yr_sum >= {1'b0, n_q}) begin
					racy_q <= NW'(yr_sum - {1'b0, n_q});
					accy_q <= accy_q + qy_q + 16'd1;
				end else begin
					racy_q <= NW'(yr_sum);
					accy_q <= accy_q + qy_q;
				end
				i_q <= i_q + NW'(1);
			end
			S_CELL: off_q <= off;
			S_CHK: if (off_q || ram_rd) vis_q <= 1'b0;
			default: ;
		endcase
	end

endmodule

// File: sv/glos_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid line-of-sight checker
// Port-level assertions on the command and result channels.
// ----------------------------------------------------------------------------
module glos_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_cmd,
	input logic out_valid,
	input logic out_ready,
	input logic out_sat,
	input logic out_vis
);
	import glos_pkg::*;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sat) && $stable(out_vis))
		else $error("result word changed under stall");

	// No word is taken while a result waits.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	// A write produces no result next cycle.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == CmdWrite |=> !out_valid)
		else $error("result after map write");

	// A query is never answered in the cycle right after it is taken.
	a_query_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == CmdQuery |=> !out_valid)
		else $error("query answered without computation");
endmodule

bind grid_line_of_sight glos_checker u_glos_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.in_cmd   (in_ch.data.cmd),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_sat  (out_ch.data.steps_saturated),
	.out_vis  (out_ch.data.visible)
);
